// ----- src/lggg_pkg.sv -----
`default_nettype none

package lggg_pkg;

    // default fraction width of the internal Q2.F values
    localparam int FRAC_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // words held between the front and back halves
    localparam int QUEUE_DEPTH_DEF = 4;

    // saturate to the Q2.F range [-4, 4)
    function automatic longint sat(longint v, int f);
        longint hi;
        longint lo;
        hi = (longint'(4) << f) - 1;
        lo = -(longint'(4) << f);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // Q2.F product, truncated toward zero, then saturated
    function automatic longint qmul(longint a, longint b, int f);
        longint p;
        longint q;
        p = a * b;
        if (p < 0)
            q = -((-p) >>> f);
        else
            q = p >>> f;
        return sat(q, f);
    endfunction

    // Q1.15 color channel to Q2.F
    function automatic longint color_q(logic [15:0] c, int f);
        return (longint'(c) << f) >>> 15;
    endfunction

    // master percent code to factor (100 + m) / 100, truncated toward zero
    function automatic longint master_fac(int code, int f);
        int m;
        m = (code >= 128) ? code - 256 : code;
        return sat((longint'(100 + m) * (longint'(1) << f)) / 100, f);
    endfunction

    // integer square root, elaboration use only
    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bm;
        logic [63:0] r;
        res = '0;
        r   = v;
        bm  = 64'd1 << 62;
        while (bm > r)
            bm = bm >> 2;
        while (bm != 0) begin
            if (r >= res + bm) begin
                r   = r - (res + bm);
                res = (res >> 1) + bm;
            end
            else begin
                res = res >> 1;
            end
            bm = bm >> 2;
        end
        return res;
    endfunction

    // Q30 value of 2^(2^-(j+1)) as built by repeated square roots
    function automatic logic [63:0] sqrt_const(int j);
        logic [63:0] v;
        v = isqrt64(64'd1 << 61);
        for (int k = 0; k < j; k++)
            v = isqrt64(v << 30);
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/lift_gamma_gain_grade_unit.sv -----
`default_nettype none

// Lift / gamma / gain grading of an 8-bit RGB pixel stream. One pixel word is
// taken per clock and one graded word leaves per clock when the output side
// keeps up. A pixel passes six front stages (luma, shadow weight, lift term),
// the queue, then 3*FRAC_BITS+20 back stages, set mainly by the FRAC_BITS log2
// squaring stages, the FRAC_BITS+11 stages of the gamma divide and the
// FRAC_BITS exp2 product stages. The queue lets the front keep taking pixels
// while a finished word waits at the output. Configuration registers are read
// by the stages that use them, so a write also reaches pixels in flight;
// write only while the block is empty.
module lift_gamma_gain_grade_unit #(
    parameter int FRAC_BITS   = lggg_pkg::FRAC_BITS_DEF,
    parameter int QUEUE_DEPTH = lggg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      red_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      blue_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      red_out,
    output logic [7:0]                      green_out,
    output logic [7:0]                      blue_out,
    input  logic                            cfg_wr_en,
    input  logic [lggg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lggg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lggg_pkg::*;

    localparam int     W     = FRAC_BITS + 3;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic signed [W-1:0] ONE_C    = W'(ONE_L);
    localparam logic signed [W-1:0] GFLOOR_C = W'((ONE_L + 50) / 100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIFT_COLOR,
        REG_GAMMA_COLOR,
        REG_GAIN_COLOR,
        REG_LIFT_MASTER,
        REG_GAMMA_MASTER,
        REG_GAIN_MASTER
    } cfg_reg_t;

    logic [47:0]         lift_color_reg, gamma_color_reg, gain_color_reg;
    logic signed [W-1:0] lf_reg, nf_reg;
    logic [W-1:0]        gf_reg;
    logic signed [W-1:0] gn_reg [3];
    logic signed [W-1:0] mf_tbl [256];
    logic signed [W-1:0] mf_sel;
    logic [3*W-1:0]      lift_c, gamma_c, gain_n;
    logic                q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    logic [3*W-1:0]      q_in_data, q_out_data;

    // percent code to master factor
    for (genvar gi = 0; gi < 256; gi++)
    begin : g_mf
        assign mf_tbl[gi] = W'(master_fac(gi, FRAC_BITS));
    end
    assign mf_sel = mf_tbl[cfg_data[7:0]];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lift_color_reg  <= 48'h0000_0000_0000;
            gamma_color_reg <= 48'h4000_4000_4000;
            gain_color_reg  <= 48'h8000_8000_8000;
            lf_reg          <= ONE_C;
            gf_reg          <= ONE_C;
            nf_reg          <= ONE_C;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LIFT_COLOR:   lift_color_reg  <= cfg_data[47:0];
                REG_GAMMA_COLOR:  gamma_color_reg <= cfg_data[47:0];
                REG_GAIN_COLOR:   gain_color_reg  <= cfg_data[47:0];
                REG_LIFT_MASTER:  lf_reg          <= mf_sel;
                REG_GAMMA_MASTER: gf_reg          <= (mf_sel < GFLOOR_C) ? GFLOOR_C : mf_sel;
                REG_GAIN_MASTER:  nf_reg          <= mf_sel;
                default: ;
            endcase
        end
    end

    // per-channel colors, gain times master precomputed
    for (genvar gc = 0; gc < 3; gc++)
    begin : g_col
        assign lift_c[(2-gc)*W +: W]  = W'(color_q(lift_color_reg[47-16*gc -: 16], FRAC_BITS));
        assign gamma_c[(2-gc)*W +: W] = W'(color_q(gamma_color_reg[47-16*gc -: 16], FRAC_BITS));
        assign gain_n[(2-gc)*W +: W]  = gn_reg[gc];
        always_ff @(posedge clk)
        begin
            gn_reg[gc] <= W'(qmul(color_q(gain_color_reg[47-16*gc -: 16], FRAC_BITS),
                                  longint'(nf_reg), FRAC_BITS));
        end
    end

    lggg_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .lift_c    (lift_c),
        .lift_fac  (lf_reg),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_data    (q_in_data)
    );

    lggg_fifo #(
        .WIDTH (3 * W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out_data)
    );

    lggg_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_data    (q_out_data),
        .gf        (gf_reg),
        .gamma_c   (gamma_c),
        .gain_n    (gain_n),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

`default_nettype wire

// ----- src/lggg_fifo.sv -----
`default_nettype none

module lggg_fifo #(
    parameter int WIDTH = 57,
    parameter int DEPTH = lggg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);
    import lggg_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on write");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on read");

endmodule

`default_nettype wire

// ----- src/lggg_front.sv -----
`default_nettype none

module lggg_front #(
    parameter int FRAC_BITS = lggg_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   red_in,
    input  logic [7:0]                   green_in,
    input  logic [7:0]                   blue_in,
    input  logic [3*(FRAC_BITS+3)-1:0]   lift_c,
    input  logic signed [FRAC_BITS+2:0]  lift_fac,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [3*(FRAC_BITS+3)-1:0]   q_data
);
    import lggg_pkg::*;

    localparam int     W     = FRAC_BITS + 3;
    localparam int     NS    = 6;
    localparam int     LSW   = 2 * FRAC_BITS + 4;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam longint HALF_L = ONE_L / 2;
    localparam longint EPS_L  = (ONE_L + 500) / 1000;
    localparam logic [FRAC_BITS:0] WR_C = (FRAC_BITS+1)'((299 * ONE_L + 500) / 1000);
    localparam logic [FRAC_BITS:0] WG_C = (FRAC_BITS+1)'((587 * ONE_L + 500) / 1000);
    localparam logic [FRAC_BITS:0] WB_C = (FRAC_BITS+1)'((114 * ONE_L + 500) / 1000);

    // 8-bit code to Q2.F, x * ONE / 255
    logic [W-1:0] ch_tbl [256];
    for (genvar gi = 0; gi < 256; gi++)
    begin : g_tbl
        assign ch_tbl[gi] = W'((longint'(gi) << FRAC_BITS) / 255);
    end

    logic [NS-1:0]       v_reg;
    logic                en;
    logic [7:0]          pix [3];
    logic [W-1:0]        lc [3];
    logic [W-1:0]        ch1_reg [3];
    logic [W-1:0]        ch2_reg [3];
    logic [W-1:0]        ch3_reg [3];
    logic [W-1:0]        ch4_reg [3];
    logic [W-1:0]        ch5_reg [3];
    logic [W-1:0]        shadow2_reg;
    logic signed [W-1:0] p3_reg [3];
    logic signed [W-1:0] p4_reg [3];
    logic signed [W-1:0] p5_reg [3];
    logic [W-1:0]        x6_reg [3];
    logic [W-1:0]        x_next [3];
    logic [LSW-1:0]      lsum;
    logic [LSW-1:0]      dluma;
    logic [W-1:0]        shadow_next;

    assign pix[0]   = red_in;
    assign pix[1]   = green_in;
    assign pix[2]   = blue_in;
    assign en       = !v_reg[NS-1] || q_ready;
    assign in_ready = en;
    assign q_valid  = v_reg[NS-1];

    for (genvar gc = 0; gc < 3; gc++)
    begin : g_io
        assign lc[gc] = lift_c[(2-gc)*W +: W];
        assign q_data[(2-gc)*W +: W] = x6_reg[gc];
    end

    // luma and shadow weight
    always_comb
    begin
        lsum = LSW'(ch1_reg[0]) * LSW'(WR_C) + LSW'(ch1_reg[1]) * LSW'(WG_C)
             + LSW'(ch1_reg[2]) * LSW'(WB_C);
        dluma = (lsum >> FRAC_BITS) << 1;
        if (dluma >= LSW'(ONE_L))
            shadow_next = '0;
        else
            shadow_next = W'(LSW'(ONE_L) - dluma);
    end

    // add lift term, floor at 0.001
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            longint xs;
            xs = sat(longint'(ch5_reg[i]) + longint'(p5_reg[i]), FRAC_BITS);
            if (xs < EPS_L)
                xs = EPS_L;
            x_next[i] = W'(xs);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NS-2:0], in_valid};
    end

    // data stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ch1_reg[i] <= ch_tbl[pix[i]];
                ch2_reg[i] <= ch1_reg[i];
                ch3_reg[i] <= ch2_reg[i];
                ch4_reg[i] <= ch3_reg[i];
                ch5_reg[i] <= ch4_reg[i];
                p3_reg[i]  <= W'(qmul(longint'(lc[i]), longint'(shadow2_reg), FRAC_BITS));
                p4_reg[i]  <= W'(qmul(longint'(p3_reg[i]), HALF_L, FRAC_BITS));
                p5_reg[i]  <= W'(qmul(longint'(p4_reg[i]), longint'(lift_fac), FRAC_BITS));
                x6_reg[i]  <= x_next[i];
            end
            shadow2_reg <= shadow_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/lggg_back.sv -----
`default_nettype none

module lggg_back #(
    parameter int FRAC_BITS = lggg_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    output logic                        q_ready,
    input  logic [3*(FRAC_BITS+3)-1:0]  q_data,
    input  logic [FRAC_BITS+2:0]        gf,
    input  logic [3*(FRAC_BITS+3)-1:0]  gamma_c,
    input  logic [3*(FRAC_BITS+3)-1:0]  gain_n,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  red_out,
    output logic [7:0]                  green_out,
    output logic [7:0]                  blue_out
);
    import lggg_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int W  = F + 3;
    localparam int PW = $clog2(W);
    localparam int LW = F + 6;
    localparam int MW = F + 5;
    localparam int QX = 11;
    localparam int QW = F + QX;
    localparam int RW = W + 1;
    localparam int TW = QW + 1;
    localparam int KW = TW - F;
    // x, encode, normalize, squarings, log, divide, split, exp2, shift, two muls, out
    localparam int NB = 3 + F + 1 + QW + 1 + F + 1 + 3;
    localparam logic signed [W-1:0] SAT_HI_C = W'((longint'(4) << F) - 1);
    localparam logic signed [TW-1:0] TWO_C   = TW'(longint'(2) << F);

    logic [NB-1:0] vb_reg;
    logic          be;
    logic [7:0]    o_next [3];
    logic [7:0]    o_reg [3];

    assign be        = !vb_reg[NB-1] || out_ready;
    assign q_ready   = be;
    assign out_valid = vb_reg[NB-1];
    assign red_out   = o_reg[0];
    assign green_out = o_reg[1];
    assign blue_out  = o_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= '0;
        else if (be)
            vb_reg <= {vb_reg[NB-2:0], q_valid};
    end

    always_ff @(posedge clk)
    begin
        if (be)
        begin
            for (int i = 0; i < 3; i++)
                o_reg[i] <= o_next[i];
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_ch
        logic [W-1:0]        x0_reg, x1_reg;
        logic [PW-1:0]       p1_reg;
        logic [PW-1:0]       enc_p;
        logic [F:0]          norm_m;
        logic [F:0]          sq_m_reg [F+1];
        logic [F-1:0]        sq_f_reg [F+1];
        logic [PW-1:0]       sq_p_reg [F+1];
        logic signed [LW-1:0] pe, lg;
        logic [MW-1:0]       mag;
        logic [MW+F-1:0]     nfull;
        logic [RW-1:0]       dv_rem_reg [QW+1];
        logic [QW-1:0]       dv_num_reg [QW+1];
        logic [QW-1:0]       dv_q_reg [QW+1];
        logic                dv_neg_reg [QW+1];
        logic signed [TW-1:0] t_s;
        logic [30:0]         ex_res_reg [F+1];
        logic [F-1:0]        ex_r_reg [F+1];
        logic signed [KW-1:0] ex_k_reg [F+1];
        logic                ex_hi_reg [F+1];
        logic [F:0]          sh_q;
        logic [KW-1:0]       sh_n;
        logic signed [W-1:0] v_next;
        logic signed [W-1:0] v_reg, g1_reg, g2_reg;
        logic [W+7:0]        o_prod;
        logic [W+7-F:0]      o_int;

        // leading one of x
        always_comb
        begin
            enc_p = '0;
            for (int b = 0; b < W; b++)
            begin
                if (x0_reg[b])
                    enc_p = PW'(b);
            end
        end

        // mantissa into [1, 2)
        always_comb
        begin
            if (int'(p1_reg) >= F)
                norm_m = (F+1)'(x1_reg >> (int'(p1_reg) - F));
            else
                norm_m = (F+1)'(x1_reg << (F - int'(p1_reg)));
        end

        // log2 result, magnitude and dividend split
        always_comb
        begin
            pe    = $signed(LW'(sq_p_reg[F])) - $signed(LW'(F));
            lg    = (pe <<< F) + $signed(LW'(sq_f_reg[F]));
            mag   = lg[LW-1] ? MW'(-lg) : MW'(lg);
            nfull = {mag, {F{1'b0}}};
        end

        // signed exponent t
        always_comb
        begin
            if (dv_neg_reg[QW])
                t_s = -$signed(TW'(dv_q_reg[QW]));
            else
                t_s = $signed(TW'(dv_q_reg[QW]));
        end

        // 2^frac to Q.F, then shift by the integer part
        always_comb
        begin
            sh_q = ex_res_reg[F][30:30-F];
            sh_n = KW'(-ex_k_reg[F]);
            if (ex_hi_reg[F])
                v_next = SAT_HI_C;
            else if (!ex_k_reg[F][KW-1])
                v_next = ex_k_reg[F][0] ? $signed(W'({sh_q, 1'b0})) : $signed(W'(sh_q));
            else
                v_next = $signed(W'(sh_q >> sh_n));
        end

        // scale to 0..255
        always_comb
        begin
            o_prod = (W+8)'(g2_reg[W-1:0]) * (W+8)'(255);
            o_int  = o_prod[W+7:F];
            if (g2_reg <= 0)
                o_next[c] = '0;
            else if (o_int > (W+8-F)'(255))
                o_next[c] = 8'd255;
            else
                o_next[c] = o_int[7:0];
        end

        // single stages
        always_ff @(posedge clk)
        begin
            if (be)
            begin
                x0_reg <= q_data[(2-c)*W +: W];
                x1_reg <= x0_reg;
                p1_reg <= enc_p;
                sq_m_reg[0] <= norm_m;
                sq_f_reg[0] <= '0;
                sq_p_reg[0] <= p1_reg;
                dv_rem_reg[0] <= RW'(nfull >> QW);
                dv_num_reg[0] <= nfull[QW-1:0];
                dv_q_reg[0]   <= '0;
                dv_neg_reg[0] <= lg[LW-1];
                ex_res_reg[0] <= 31'(longint'(1) << 30);
                ex_r_reg[0]   <= t_s[F-1:0];
                ex_k_reg[0]   <= t_s[TW-1:F];
                ex_hi_reg[0]  <= (t_s >= TWO_C);
                v_reg  <= v_next;
                g1_reg <= W'(qmul(longint'(v_reg),
                              longint'($signed(gamma_c[(2-c)*W +: W])), F));
                g2_reg <= W'(qmul(longint'(g1_reg),
                              longint'($signed(gain_n[(2-c)*W +: W])), F));
            end
        end

        // log2 fraction, one squaring per stage
        for (genvar j = 0; j < F; j++)
        begin : g_sq
            logic [2*F+1:0] prod;
            logic [F+1:0]   mm;
            logic [F-1:0]   f_next;
            always_comb
            begin
                prod   = (2*F+2)'(sq_m_reg[j]) * (2*F+2)'(sq_m_reg[j]);
                mm     = prod[2*F+1:F];
                f_next = sq_f_reg[j];
                f_next[F-1-j] = mm[F+1];
            end
            always_ff @(posedge clk)
            begin
                if (be)
                begin
                    sq_m_reg[j+1] <= mm[F+1] ? mm[F+1:1] : mm[F:0];
                    sq_f_reg[j+1] <= f_next;
                    sq_p_reg[j+1] <= sq_p_reg[j];
                end
            end
        end

        // restoring divide by the gamma factor, one quotient bit per stage
        for (genvar j = 0; j < QW; j++)
        begin : g_div
            logic [RW-1:0] r2;
            logic          ge;
            always_comb
            begin
                r2 = {dv_rem_reg[j][RW-2:0], dv_num_reg[j][QW-1]};
                ge = (r2 >= {1'b0, gf});
            end
            always_ff @(posedge clk)
            begin
                if (be)
                begin
                    dv_rem_reg[j+1] <= ge ? r2 - {1'b0, gf} : r2;
                    dv_num_reg[j+1] <= dv_num_reg[j] << 1;
                    dv_q_reg[j+1]   <= {dv_q_reg[j][QW-2:0], ge};
                    dv_neg_reg[j+1] <= dv_neg_reg[j];
                end
            end
        end

        // exp2 of the fraction, one root constant per stage
        for (genvar j = 0; j < F; j++)
        begin : g_exp
            localparam logic [30:0] VC = 31'(sqrt_const(j));
            logic [61:0] prod;
            always_comb
            begin
                prod = 62'(ex_res_reg[j]) * 62'(VC);
            end
            always_ff @(posedge clk)
            begin
                if (be)
                begin
                    ex_res_reg[j+1] <= ex_r_reg[j][F-1-j] ? prod[60:30] : ex_res_reg[j];
                    ex_r_reg[j+1]   <= ex_r_reg[j];
                    ex_k_reg[j+1]   <= ex_k_reg[j];
                    ex_hi_reg[j+1]  <= ex_hi_reg[j];
                end
            end
        end
    end

endmodule

`default_nettype wire
